// ----- design/wfsd_pkg.sv -----
`default_nettype none

package wfsd_pkg;

    localparam int unsigned MaxVarintBytesDefault = 10;
    localparam logic [31:0] MaxLengthReset        = 32'd1048576;

    // wire types carried in the low three bits of a key
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    localparam logic [7:0] VarintMore = 8'h80;
    localparam logic [7:0] VarintData = 8'h7f;

    typedef enum logic [2:0] {
        PH_KEY     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_FIX64   = 3'd2,
        PH_FIX32   = 3'd3,
        PH_LEN     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_SKIP    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SCALAR  = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_WIRETYPE = 2'd1,
        ERR_LENGTH   = 2'd2,
        ERR_OVERLONG = 2'd3
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [60:0] tag;
        logic [2:0]  wire_type;
        logic [63:0] value;
        logic [7:0]  payload_byte;
        logic        last_payload;
        err_t        error_code;
    } result_t;

endpackage

`default_nettype wire

// ----- design/wfsd_parser.sv -----
`default_nettype none

module wfsd_parser
    import wfsd_pkg::*;
#(
    parameter int unsigned MAX_VARINT_BYTES = MaxVarintBytesDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        step_en,
    input  wire logic [7:0]  byte_in,
    output logic             res_valid,
    output result_t          res
);

    logic [31:0] max_length_reg;
    phase_t      phase_reg, phase_next;
    logic [3:0]  byte_count_reg, byte_count_next;
    logic [63:0] acc_reg, acc_next;
    logic [60:0] held_tag_reg, held_tag_next;
    logic [2:0]  held_wt_reg, held_wt_next;
    logic [31:0] bytes_left_reg, bytes_left_next;

    logic [6:0]  vshift;
    logic [63:0] vacc;
    logic        vmore;
    logic        vlong;
    logic [3:0]  bc_inc;
    logic [63:0] facc;
    logic [3:0]  fneed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MaxLengthReset;
        end
        else if (cfg_wr_en)
        begin
            max_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_KEY;
            byte_count_reg <= '0;
            acc_reg        <= '0;
            held_tag_reg   <= '0;
            held_wt_reg    <= '0;
            bytes_left_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            acc_reg        <= acc_next;
            held_tag_reg   <= held_tag_next;
            held_wt_reg    <= held_wt_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    // per-byte arithmetic shared by the phases
    always_comb
    begin
        vshift = {3'b000, byte_count_reg} * 7'd7;
        if (vshift < 7'd64)
        begin
            vacc = acc_reg | ({56'b0, byte_in & VarintData} << vshift[5:0]);
        end
        else
        begin
            vacc = acc_reg;
        end
        vmore  = (byte_in & VarintMore) != 8'h00;
        bc_inc = byte_count_reg + 4'd1;
        vlong  = vmore && ({1'b0, byte_count_reg} + 5'd1 >= 5'(MAX_VARINT_BYTES));
        facc   = acc_reg | ({56'b0, byte_in} << {byte_count_reg[2:0], 3'b000});
        fneed  = (phase_reg == PH_FIX64) ? 4'd8 : 4'd4;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        acc_next        = acc_reg;
        held_tag_next   = held_tag_reg;
        held_wt_next    = held_wt_reg;
        bytes_left_next = bytes_left_reg;
        res_valid       = 1'b0;
        res             = '0;
        res.tag         = held_tag_reg;
        res.wire_type   = held_wt_reg;

        unique case (phase_reg)
            PH_VARINT, PH_LEN:
            begin
                acc_next = vacc;
                if (!vmore)
                begin
                    res_valid       = 1'b1;
                    res.value       = vacc;
                    phase_next      = PH_KEY;
                    byte_count_next = '0;
                    acc_next        = '0;
                    if (phase_reg == PH_VARINT)
                    begin
                        res.kind = KIND_SCALAR;
                    end
                    else if (vacc > {32'b0, max_length_reg})
                    begin
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_LENGTH;
                    end
                    else
                    begin
                        res.kind = KIND_HEADER;
                        if (vacc != 64'd0)
                        begin
                            bytes_left_next = vacc[31:0];
                            phase_next      = PH_PAYLOAD;
                        end
                    end
                end
                else if (vlong)
                begin
                    phase_next     = PH_SKIP;
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_OVERLONG;
                end
                else
                begin
                    byte_count_next = bc_inc;
                end
            end

            PH_FIX64, PH_FIX32:
            begin
                if (bc_inc < fneed)
                begin
                    acc_next        = facc;
                    byte_count_next = bc_inc;
                end
                else
                begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_SCALAR;
                    res.value       = facc;
                    phase_next      = PH_KEY;
                    byte_count_next = '0;
                    acc_next        = '0;
                end
            end

            PH_PAYLOAD:
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = byte_in;
                if (bytes_left_reg <= 32'd1)
                begin
                    res.last_payload = 1'b1;
                    bytes_left_next  = '0;
                    phase_next       = PH_KEY;
                    byte_count_next  = '0;
                    acc_next         = '0;
                end
                else
                begin
                    bytes_left_next = bytes_left_reg - 32'd1;
                end
            end

            PH_SKIP:
            begin
                if (!vmore)
                begin
                    phase_next      = PH_KEY;
                    byte_count_next = '0;
                    acc_next        = '0;
                end
            end

            // key, and the unused phase code
            default:
            begin
                phase_next = PH_KEY;
                acc_next   = vacc;
                if (!vmore)
                begin
                    held_tag_next   = vacc[63:3];
                    held_wt_next    = vacc[2:0];
                    byte_count_next = '0;
                    acc_next        = '0;
                    res.tag         = vacc[63:3];
                    res.wire_type   = vacc[2:0];
                    unique case (vacc[2:0])
                        WT_VARINT:
                        begin
                            phase_next = PH_VARINT;
                        end
                        WT_FIX64:
                        begin
                            phase_next = PH_FIX64;
                        end
                        WT_LEN:
                        begin
                            phase_next = PH_LEN;
                        end
                        WT_FIX32:
                        begin
                            phase_next = PH_FIX32;
                        end
                        default:
                        begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_WIRETYPE;
                        end
                    endcase
                end
                else if (vlong)
                begin
                    held_tag_next  = '0;
                    held_wt_next   = '0;
                    phase_next     = PH_SKIP;
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.tag        = '0;
                    res.wire_type  = '0;
                    res.error_code = ERR_OVERLONG;
                end
                else
                begin
                    byte_count_next = bc_inc;
                end
            end
        endcase
    end

    a_payload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> bytes_left_reg != 32'd0)
        else $error("payload phase with no bytes left");

    a_varint_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_KEY || phase_reg == PH_VARINT || phase_reg == PH_LEN)
        |-> {1'b0, byte_count_reg} < 5'(MAX_VARINT_BYTES))
        else $error("varint byte count past limit");

    a_fixed_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FIX64 || phase_reg == PH_FIX32) |-> byte_count_reg < 4'd8)
        else $error("fixed word byte count out of range");

    a_error_coded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.kind == KIND_ERROR) == (res.error_code != ERR_NONE)))
        else $error("error kind and error code disagree");

    a_key_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res_valid && res.kind == KIND_HEADER && res.value == 64'd0
        |=> phase_reg == PH_KEY)
        else $error("empty field did not return to key");

endmodule

`default_nettype wire

// ----- design/wfsd_out_stage.sv -----
`default_nettype none

module wfsd_out_stage
    import wfsd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t res_in,
    input  wire logic    ready,
    output logic         can_load,
    output logic         valid,
    output result_t      res_out
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // free, or emptied by the sink in this cycle
    assign can_load = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            res_reg <= res_in;
        end
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire

// ----- design/wire_field_stream_decoder.sv -----
`default_nettype none

// Streaming decoder for the protobuf wire format, one byte per item. Each
// key varint is split into a field tag and a wire type; the value follows as
// a varint, a little-endian fixed64 or fixed32 word, or a length varint and
// the payload bytes. Results are: a scalar item per finished scalar field, a
// header item per length field, one item per payload byte (last marked), and
// an error item for a bad wire type, a length above max_length or a varint
// that runs past MAX_VARINT_BYTES bytes; after an overlong varint the stream
// is dropped up to the end of that varint, otherwise parsing resumes at the
// next byte as a key. Many bytes yield no result. Throughput is one byte per
// clock: the byte is held in an input register, the parse step is a single
// pass of logic into the result register, and in_ready stays high as long as
// the result register is free or being drained. A byte goes from the input
// register through the parse step into the result register and the output.
// max_length may be rewritten only while the block is idle.
module wire_field_stream_decoder
    import wfsd_pkg::*;
#(
    parameter int unsigned MAX_VARINT_BYTES = MaxVarintBytesDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration: max_length
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,

    // byte items in
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,

    // result items out
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [60:0]      tag,
    output logic [2:0]       wire_type,
    output logic [63:0]      value,
    output logic [7:0]       payload_byte,
    output logic             last_payload,
    output logic [1:0]       error_code
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  data_reg;
    logic        step_en;
    logic        out_can_load;
    logic        step_res_valid;
    result_t     step_res;
    result_t     out_res;

    // the held byte is parsed once the result register can take its result
    assign step_en  = in_valid_reg && out_can_load;
    assign in_ready = !in_valid_reg || step_en;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // byte register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_byte;
        end
    end

    wfsd_parser #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (step_en),
        .byte_in     (data_reg),
        .res_valid   (step_res_valid),
        .res         (step_res)
    );

    wfsd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step_en && step_res_valid),
        .res_in   (step_res),
        .ready    (out_ready),
        .can_load (out_can_load),
        .valid    (out_valid),
        .res_out  (out_res)
    );

    // result fields onto their own ports
    assign kind         = out_res.kind;
    assign tag          = out_res.tag;
    assign wire_type    = out_res.wire_type;
    assign value        = out_res.value;
    assign payload_byte = out_res.payload_byte;
    assign last_payload = out_res.last_payload;
    assign error_code   = out_res.error_code;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
module tb
    import wfsd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // varint length limit of the block as instantiated (default parameter)
    localparam int unsigned MaxVarint = MaxVarintBytesDefault;
    // receiver hold-off used once to back the block up into its input
    localparam int unsigned LongHold = 300;

    typedef enum logic [1:0] {
        V_MORE,
        V_DONE,
        V_LONG
    } varint_step_t;

    // ------------------------------------------------------------------
    // decoder state mirror and store of expected result items
    // ------------------------------------------------------------------
    class field_checker;
        phase_t      phase;
        logic [3:0]  count;
        logic [63:0] acc;
        logic [60:0] tag_hold;
        logic [2:0]  wt_hold;
        logic [31:0] left;
        logic [31:0] max_len;
        result_t     pending_fields[$];
        int unsigned mismatches;

        function new();
            phase      = PH_KEY;
            count      = '0;
            acc        = '0;
            tag_hold   = '0;
            wt_hold    = '0;
            left       = '0;
            max_len    = MaxLengthReset;
            mismatches = 0;
        endfunction

        task report(input string what);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        function void restart(input phase_t next_phase);
            phase = next_phase;
            count = '0;
            acc   = '0;
        endfunction

        function varint_step_t take_varint(input logic [7:0] b);
            int unsigned shift;
            shift = 7 * count;
            // data bits that would land above bit 63 are dropped
            if (shift < 64)
                acc = acc | (64'(b & VarintData) << shift);
            if ((b & VarintMore) == 8'd0)
                return V_DONE;
            if (count + 1 >= MaxVarint)
                return V_LONG;
            count = count + 4'd1;
            return V_MORE;
        endfunction

        function result_t make_field(input kind_t k, input logic [63:0] v,
                                     input logic [7:0] pb, input logic lp,
                                     input err_t e);
            result_t f;
            f.kind         = k;
            f.tag          = tag_hold;
            f.wire_type    = wt_hold;
            f.value        = v;
            f.payload_byte = pb;
            f.last_payload = lp;
            f.error_code   = e;
            return f;
        endfunction

        // one accepted byte: advance the parse and queue any result it causes
        function void decode_byte(input logic [7:0] b);
            varint_step_t st;
            logic [63:0]  v;
            int unsigned  n;
            logic         is_last;
            logic         have;
            result_t      f;
            have = 1'b0;
            case (phase)
                PH_VARINT, PH_LEN: begin
                    st = take_varint(b);
                    if (st == V_LONG) begin
                        phase = PH_SKIP;
                        f     = make_field(KIND_ERROR, '0, '0, 1'b0, ERR_OVERLONG);
                        have  = 1'b1;
                    end else if (st == V_DONE) begin
                        v    = acc;
                        have = 1'b1;
                        if (phase == PH_VARINT) begin
                            restart(PH_KEY);
                            f = make_field(KIND_SCALAR, v, '0, 1'b0, ERR_NONE);
                        end else begin
                            restart(PH_KEY);
                            if (v > {32'd0, max_len}) begin
                                f = make_field(KIND_ERROR, v, '0, 1'b0, ERR_LENGTH);
                            end else begin
                                // zero length: header only, no payload follows
                                if (v != 64'd0) begin
                                    left  = v[31:0];
                                    phase = PH_PAYLOAD;
                                end
                                f = make_field(KIND_HEADER, v, '0, 1'b0, ERR_NONE);
                            end
                        end
                    end
                end
                PH_FIX64, PH_FIX32: begin
                    n     = (phase == PH_FIX64) ? 8 : 4;
                    acc   = acc | (64'(b) << ((8 * count) & 63));
                    count = count + 4'd1;
                    if (count >= n) begin
                        v = acc;
                        restart(PH_KEY);
                        f    = make_field(KIND_SCALAR, v, '0, 1'b0, ERR_NONE);
                        have = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    is_last = (left <= 32'd1);
                    if (is_last) begin
                        left = '0;
                        restart(PH_KEY);
                    end else begin
                        left = left - 32'd1;
                    end
                    f    = make_field(KIND_PAYLOAD, '0, b, is_last, ERR_NONE);
                    have = 1'b1;
                end
                PH_SKIP: begin
                    if ((b & VarintMore) == 8'd0)
                        restart(PH_KEY);
                end
                default: begin
                    phase = PH_KEY;
                    st    = take_varint(b);
                    if (st == V_LONG) begin
                        tag_hold = '0;
                        wt_hold  = '0;
                        phase    = PH_SKIP;
                        f        = make_field(KIND_ERROR, '0, '0, 1'b0, ERR_OVERLONG);
                        have     = 1'b1;
                    end else if (st == V_DONE) begin
                        tag_hold = acc[63:3];
                        wt_hold  = acc[2:0];
                        case (wt_hold)
                            WT_VARINT: restart(PH_VARINT);
                            WT_FIX64:  restart(PH_FIX64);
                            WT_LEN:    restart(PH_LEN);
                            WT_FIX32:  restart(PH_FIX32);
                            default: begin
                                restart(PH_KEY);
                                f    = make_field(KIND_ERROR, '0, '0, 1'b0, ERR_WIRETYPE);
                                have = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
            if (have)
                pending_fields.push_back(f);
        endfunction

        task check_field(input result_t got);
            result_t want;
            string   diff;
            if (pending_fields.size() == 0) begin
                report($sformatf("result item kind %0d tag %0h with nothing expected",
                                 got.kind, got.tag));
                return;
            end
            want = pending_fields.pop_front();
            diff = "";
            if (got.kind !== want.kind)
                diff = {diff, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
            if (got.tag !== want.tag)
                diff = {diff, $sformatf(" tag %0h/%0h", got.tag, want.tag)};
            if (got.wire_type !== want.wire_type)
                diff = {diff, $sformatf(" wire_type %0d/%0d", got.wire_type,
                                        want.wire_type)};
            if (got.value !== want.value)
                diff = {diff, $sformatf(" value %0h/%0h", got.value, want.value)};
            if (got.payload_byte !== want.payload_byte)
                diff = {diff, $sformatf(" payload_byte %0h/%0h", got.payload_byte,
                                        want.payload_byte)};
            if (got.last_payload !== want.last_payload)
                diff = {diff, $sformatf(" last_payload %0b/%0b", got.last_payload,
                                        want.last_payload)};
            if (got.error_code !== want.error_code)
                diff = {diff, $sformatf(" error_code %0d/%0d", got.error_code,
                                        want.error_code)};
            if (diff != "")
                report({"result item got/expected:", diff});
        endtask
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte   = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [1:0]  kind;
    logic [60:0] tag;
    logic [2:0]  wire_type;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [1:0]  error_code;

    field_checker board;
    result_t      seen;
    logic [7:0]   byte_stream[$];
    // no gaps on either side while set
    bit           steady       = 1'b0;
    // asks the receiver for one long hold-off
    bit           hold_request = 1'b0;

    wire_field_stream_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .tag          (tag),
        .wire_type    (wire_type),
        .value        (value),
        .payload_byte (payload_byte),
        .last_payload (last_payload),
        .error_code   (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // gap length: mostly none or short, now and then a long one
    function int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // stream building
    // ------------------------------------------------------------------

    // base-128 encoding, optionally padded with extra continuation bytes;
    // a full ten-byte varint may carry junk bits above bit 63
    task add_varint(input logic [63:0] v, input bit padded);
        int unsigned need;
        int unsigned n;
        logic [63:0] rest;
        logic [7:0]  b;
        need = 1;
        for (rest = v >> 7; rest != 64'd0; rest = rest >> 7)
            need++;
        n = padded ? $urandom_range(need, MaxVarint) : need;
        for (int i = 0; i < n; i++)
        begin
            b = {1'b0, 7'(v >> (7 * i))};
            if (i + 1 < n)
                b = b | VarintMore;
            else if (i == MaxVarint - 1 && $urandom_range(0, 1) == 1)
                b[6:1] = 6'($urandom);
            byte_stream.push_back(b);
        end
    endtask

    task add_key(input logic [60:0] t, input logic [2:0] wt);
        add_varint({t, wt}, $urandom_range(0, 4) == 0);
    endtask

    // continuation bytes past the varint limit, then the byte that ends the skip
    task add_overlong();
        int unsigned n;
        n = $urandom_range(MaxVarint, MaxVarint + 3);
        repeat (n) byte_stream.push_back(8'($urandom) | VarintMore);
        byte_stream.push_back(8'($urandom) & VarintData);
    endtask

    function logic [60:0] pick_tag();
        int unsigned r;
        int unsigned w;
        logic [63:0] t;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '1;
        if (r == 1)
            return '0;
        w = $urandom_range(1, 61);
        t = {$urandom(), $urandom()};
        return t[60:0] & ((61'd1 << w) - 61'd1);
    endfunction

    function logic [63:0] pick_value();
        int unsigned w;
        logic [63:0] v;
        if ($urandom_range(0, 15) == 0)
            return '0;
        w = $urandom_range(1, 64);
        v = {$urandom(), $urandom()};
        if (w < 64)
            v = v & ((64'd1 << w) - 64'd1);
        return v;
    endfunction

    // one field: mostly well formed with random content, some errors and noise
    task add_field();
        int unsigned pick;
        int unsigned len;
        logic [60:0] t;
        logic [63:0] v;
        logic [2:0]  wt;
        t    = pick_tag();
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            add_key(t, WT_VARINT);
            add_varint(pick_value(), $urandom_range(0, 4) == 0);
        end else if (pick < 34) begin
            add_key(t, WT_FIX64);
            repeat (8) byte_stream.push_back(8'($urandom));
        end else if (pick < 46) begin
            add_key(t, WT_FIX32);
            repeat (4) byte_stream.push_back(8'($urandom));
        end else if (pick < 72) begin
            // mostly short payloads, a few longer ones
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            add_key(t, WT_LEN);
            add_varint(64'(len), $urandom_range(0, 4) == 0);
            repeat (len) byte_stream.push_back(8'($urandom));
        end else if (pick < 80) begin
            // length above the limit, either just over it or far beyond
            if ($urandom_range(0, 1) == 0)
                v = {32'd0, board.max_len} + 64'($urandom_range(1, 4));
            else
                v = {$urandom(), $urandom()};
            if (v <= {32'd0, board.max_len})
                v = {32'd0, board.max_len} + 64'd1;
            add_key(t, WT_LEN);
            add_varint(v, $urandom_range(0, 4) == 0);
        end else if (pick < 86) begin
            do
                wt = 3'($urandom_range(3, 7));
            while (wt == WT_FIX32);
            add_key(t, wt);
        end else if (pick < 92) begin
            // overlong varint in the key, a scalar value or a length
            case ($urandom_range(0, 2))
                0: ;
                1: add_key(t, WT_VARINT);
                default: add_key(t, WT_LEN);
            endcase
            add_overlong();
        end else if (pick < 96) begin
            // fixed field cut short, the next bytes are taken as its value
            add_key(t, ($urandom_range(0, 1) == 0) ? WT_FIX64 : WT_FIX32);
            repeat ($urandom_range(1, 3)) byte_stream.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 3)) byte_stream.push_back(8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // offer every byte of the stream, noting each one as it is accepted
    task send_stream();
        int unsigned gap;
        for (int i = 0; i < byte_stream.size(); i++)
        begin
            in_valid  <= 1'b1;
            data_byte <= byte_stream[i];
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            board.decode_byte(byte_stream[i]);
            gap = steady ? 0 : idle_len();
            if (gap != 0 || i == byte_stream.size() - 1) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        byte_stream.delete();
    endtask

    task run_messages(input int unsigned n);
        while (byte_stream.size() < n)
            add_field();
        send_stream();
    endtask

    // drain all expected items, then let bytes with no result clear the pipe
    task wait_idle();
        repeat (2) @(posedge clk);
        while (board.pending_fields.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task set_max_length(input logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        board.max_len = v;
    endtask

    // receiver: runs of ready with random stalls, plus one long hold-off
    initial
    begin
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LongHold) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat (steady ? 1 : $urandom_range(1, 12)) @(posedge clk);
            stall = steady ? 0 : idle_len();
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // result items are checked at the edge where they are taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            seen.kind         = kind_t'(kind);
            seen.tag          = tag;
            seen.wire_type    = wire_type;
            seen.value        = value;
            seen.payload_byte = payload_byte;
            seen.last_payload = last_payload;
            seen.error_code   = err_t'(error_code);
            board.check_field(seen);
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at the reset length limit
        byte_stream = {
            8'h08, 8'h01,                                   // varint field
            8'h15, 8'hef, 8'hbe, 8'had, 8'hde,              // fixed32 field
            8'h19, 8'hff, 8'hff, 8'hff, 8'hff,              // fixed64, all ones
            8'hff, 8'hff, 8'hff, 8'hff,
            8'h22, 8'h01, 8'hff,                            // one payload byte
            8'h2a, 8'h00,                                   // zero length
            8'h0b,                                          // bad wire type
            8'h32, 8'h81, 8'h80, 8'h40,                     // one above the limit
            8'hff, 8'hff, 8'hff, 8'hff, 8'hff,              // overlong key
            8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
            8'h7f                                           // ends the skip
        };
        send_stream();

        // random fields, with one long receiver hold-off to fill the block
        hold_request = 1'b1;
        run_messages(400);

        // no payload allowed at all
        wait_idle();
        set_max_length('0);
        run_messages(300);

        // widest limit, back to back on both sides
        wait_idle();
        steady = 1'b1;
        set_max_length('1);
        run_messages(350);

        // small limit, payload lengths straddle it
        wait_idle();
        steady = 1'b0;
        set_max_length(32'($urandom_range(1, 16)));
        run_messages(350);

        wait_idle();
        set_max_length($urandom());
        run_messages(350);

        wait_idle();
        if (board.mismatches == 0)
            $display("wire_field_stream_decoder test passed");
        else
            $display("wire_field_stream_decoder test failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #50ms;
        $display("wire_field_stream_decoder test failed");
        $finish;
    end

endmodule
